// ----- sv/hsi_to_rgbw_converter_top_macros.svh -----
// Assertion macros shared by the converter's checking code.
`ifndef HSI_TO_RGBW_CONVERTER_TOP_MACROS_SVH
`define HSI_TO_RGBW_CONVERTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hrc_pkg.sv -----
package hrc_pkg;

    // Default PWM resolution.
    localparam int DUTY_BITS_DEF = 12;

    // Field and internal widths.
    localparam int HUE_W     = 9;
    localparam int PCT_W     = 7;
    localparam int DEG_W     = 7;
    localparam int TAN_IDX_W = 6;
    localparam int TAN_W     = 15;
    localparam int RATIO_W   = 16;
    localparam int PROD_W    = 14;
    localparam int MUL_W     = PROD_W + RATIO_W;
    localparam int X_W       = 29;

    // Input limits and sector boundaries.
    localparam logic [HUE_W-1:0] HUE_MAX     = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECTOR  = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SECTOR2 = 9'd240;
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [DEG_W-1:0] DEG_MID     = 7'd60;

    // Ratio factors in Q2.14: (1 + q) at q = 1/2, and (1 + q) + (2 - q).
    localparam logic [RATIO_W-1:0] RATIO_MID = 16'd24576;
    localparam logic [RATIO_W-1:0] RATIO_SUM = 16'd49152;

    // Common denominator 30000 * 2^14 = 1875 * 2^18.
    localparam int DEN_SHIFT = 18;
    localparam int DEN_ODD   = 1875;

    typedef enum logic [1:0] {
        SEC_RG = 2'd0,
        SEC_GB = 2'd1,
        SEC_BR = 2'd2
    } t_sector;

    // Stage enables of the front end.
    typedef struct packed {
        logic s2_en;
        logic s1_en;
        logic s0_en;
    } t_fe_ctl;

    // Stage enables of one divider lane.
    typedef struct packed {
        logic d3_en;
        logic d2_en;
        logic d1_en;
        logic d0_en;
    } t_div_ctl;

    // Scaled tangent 16384 * (sqrt(3)/2) * tan(k) for k = 0..60 degrees.
    localparam logic [TAN_W-1:0] TAN_TBL [0:60] = '{
        15'd0,     15'd248,   15'd495,   15'd744,   15'd992,
        15'd1241,  15'd1491,  15'd1742,  15'd1994,  15'd2247,
        15'd2502,  15'd2758,  15'd3016,  15'd3276,  15'd3538,
        15'd3802,  15'd4069,  15'd4338,  15'd4610,  15'd4886,
        15'd5164,  15'd5447,  15'd5733,  15'd6023,  15'd6317,
        15'd6616,  15'd6920,  15'd7230,  15'd7544,  15'd7865,
        15'd8192,  15'd8526,  15'd8866,  15'd9214,  15'd9571,
        15'd9935,  15'd10309, 15'd10692, 15'd11086, 15'd11490,
        15'd11906, 15'd12334, 15'd12776, 15'd13231, 15'd13702,
        15'd14189, 15'd14693, 15'd15216, 15'd15758, 15'd16323,
        15'd16910, 15'd17522, 15'd18161, 15'd18829, 15'd19529,
        15'd20264, 15'd21036, 15'd21849, 15'd22707, 15'd23614,
        15'd24576
    };

    // Primary factor (1 + q) in Q2.14 for sector offset d in 0..120.
    function automatic logic [RATIO_W-1:0] ratio_pri(input logic [DEG_W-1:0] d);
        logic [TAN_IDX_W-1:0] idx;
        logic [RATIO_W-1:0]   res;
        if (d <= DEG_MID) begin
            idx = TAN_IDX_W'(DEG_MID - d);
            res = RATIO_MID + RATIO_W'(TAN_TBL[idx]);
        end else begin
            idx = TAN_IDX_W'(d - DEG_MID);
            res = RATIO_MID - RATIO_W'(TAN_TBL[idx]);
        end
        return res;
    endfunction

endpackage

// ----- sv/hsi_to_rgbw_converter_top.sv -----
// HSI to RGBW color converter.
// Input channel: i_valid / o_ready carry a request of hue (degrees),
// saturation and intensity (percent). Out-of-range values are clamped.
// Output channel: o_valid / i_ready carry four PWM duty values of
// DUTY_BITS bits each for the red, green, blue and white LEDs.
// The pipeline has seven register stages: three in the front end (clamp
// and ratio lookup, saturation times intensity, numerator multiply) and
// four in each divider lane (full-scale scaling, reciprocal multiply,
// remainder, correction). A new request is taken every cycle while
// o_ready is high.
// Each stage moves forward when it is empty or the stage after it moves,
// so bubbles close up while the receiver stalls; o_ready falls only when
// all seven stages hold requests and i_ready is low.
// Reset (i_rst_n low, synchronous) empties the pipeline; data registers
// are not cleared and are ignored until their valid bit is set.
module hsi_to_rgbw_converter_top #(
    parameter int DUTY_BITS = hrc_pkg::DUTY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hrc_pkg::HUE_W-1:0]   i_hue_deg,
    input  logic [hrc_pkg::PCT_W-1:0]   i_saturation_pct,
    input  logic [hrc_pkg::PCT_W-1:0]   i_intensity_pct,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [DUTY_BITS-1:0]        o_red_duty,
    output logic [DUTY_BITS-1:0]        o_green_duty,
    output logic [DUTY_BITS-1:0]        o_blue_duty,
    output logic [DUTY_BITS-1:0]        o_white_duty
);

    `include "hsi_to_rgbw_converter_top_macros.svh"

    localparam int STAGES = 7;

    logic [STAGES-1:0]       r_vld;
    logic [STAGES-1:0]       n_vld;
    logic [STAGES-1:0]       w_en;
    hrc_pkg::t_fe_ctl        w_fe_ctl;
    hrc_pkg::t_div_ctl       w_div_ctl;
    logic [hrc_pkg::X_W-1:0] w_x_red;
    logic [hrc_pkg::X_W-1:0] w_x_green;
    logic [hrc_pkg::X_W-1:0] w_x_blue;
    logic [hrc_pkg::X_W-1:0] w_x_white;

    // A stage loads when it is empty or its successor is loading.
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_fe_ctl  = '{s2_en: w_en[2], s1_en: w_en[1], s0_en: w_en[0]};
    assign w_div_ctl = '{d3_en: w_en[6], d2_en: w_en[5], d1_en: w_en[4],
                         d0_en: w_en[3]};

    // Front end: clamping, ratio lookup and per-channel numerators.
    hrc_front u_front (
        .i_clk            (i_clk),
        .i_ctl            (w_fe_ctl),
        .i_hue_deg        (i_hue_deg),
        .i_saturation_pct (i_saturation_pct),
        .i_intensity_pct  (i_intensity_pct),
        .o_x_red          (w_x_red),
        .o_x_green        (w_x_green),
        .o_x_blue         (w_x_blue),
        .o_x_white        (w_x_white)
    );

    // One constant-divider lane per LED channel.
    hrc_cdiv #(.DUTY_BITS(DUTY_BITS)) u_div_red (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_x    (w_x_red),
        .o_duty (o_red_duty)
    );

    hrc_cdiv #(.DUTY_BITS(DUTY_BITS)) u_div_green (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_x    (w_x_green),
        .o_duty (o_green_duty)
    );

    hrc_cdiv #(.DUTY_BITS(DUTY_BITS)) u_div_blue (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_x    (w_x_blue),
        .o_duty (o_blue_duty)
    );

    hrc_cdiv #(.DUTY_BITS(DUTY_BITS)) u_div_white (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_x    (w_x_white),
        .o_duty (o_white_duty)
    );

    assign o_ready = w_en[0];
    assign o_valid = r_vld[STAGES-1];

    // The input side may only stall when every stage holds a request.
    `HRC_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !o_ready, &r_vld,
        "input stalled with a bubble")
    // With the receiver ready, a request in the next-to-last stage reaches the output.
    `HRC_ASSERT_NEXT(a_advance, i_clk, i_rst_n, i_ready && r_vld[STAGES-2], o_valid,
        "request lost")
    // One color channel is always dark.
    `HRC_ASSERT_SAME(a_dark_chan, i_clk, i_rst_n, o_valid,
        (o_red_duty == '0) || (o_green_duty == '0) || (o_blue_duty == '0),
        "no dark channel")
    // Primary plus secondary never exceed full scale.
    `HRC_ASSERT_SAME(a_sum_limit, i_clk, i_rst_n, o_valid,
        (32'(o_red_duty) + 32'(o_green_duty) + 32'(o_blue_duty))
            <= ((32'd1 << DUTY_BITS) - 32'd1),
        "color sum over full scale")

endmodule

// ----- sv/hrc_front.sv -----
module hrc_front (
    input  logic                        i_clk,
    input  hrc_pkg::t_fe_ctl            i_ctl,
    input  logic [hrc_pkg::HUE_W-1:0]   i_hue_deg,
    input  logic [hrc_pkg::PCT_W-1:0]   i_saturation_pct,
    input  logic [hrc_pkg::PCT_W-1:0]   i_intensity_pct,
    output logic [hrc_pkg::X_W-1:0]     o_x_red,
    output logic [hrc_pkg::X_W-1:0]     o_x_green,
    output logic [hrc_pkg::X_W-1:0]     o_x_blue,
    output logic [hrc_pkg::X_W-1:0]     o_x_white
);

    logic [hrc_pkg::HUE_W-1:0]   w_hue;
    logic [hrc_pkg::PCT_W-1:0]   w_sat;
    logic [hrc_pkg::PCT_W-1:0]   w_int;
    logic [hrc_pkg::DEG_W-1:0]   w_deg;
    hrc_pkg::t_sector            w_sector;

    hrc_pkg::t_sector            r_s0_sector;
    logic [hrc_pkg::PCT_W-1:0]   r_s0_sat;
    logic [hrc_pkg::PCT_W-1:0]   r_s0_int;
    logic [hrc_pkg::RATIO_W-1:0] r_s0_apri;

    hrc_pkg::t_sector            r_s1_sector;
    logic [hrc_pkg::PROD_W-1:0]  r_s1_si;
    logic [hrc_pkg::PROD_W-1:0]  r_s1_w;
    logic [hrc_pkg::RATIO_W-1:0] r_s1_apri;
    logic [hrc_pkg::RATIO_W-1:0] r_s1_asec;

    logic [hrc_pkg::MUL_W-1:0]   w_xp;
    logic [hrc_pkg::MUL_W-1:0]   w_xs;
    logic [hrc_pkg::MUL_W-1:0]   w_xw;
    logic [hrc_pkg::X_W-1:0]     n_x_red;
    logic [hrc_pkg::X_W-1:0]     n_x_green;
    logic [hrc_pkg::X_W-1:0]     n_x_blue;
    logic [hrc_pkg::X_W-1:0]     r_x_red;
    logic [hrc_pkg::X_W-1:0]     r_x_green;
    logic [hrc_pkg::X_W-1:0]     r_x_blue;
    logic [hrc_pkg::X_W-1:0]     r_x_white;

    // Clamp the inputs and split the hue into a sector and an offset.
    always_comb begin
        w_hue = (i_hue_deg > hrc_pkg::HUE_MAX) ? hrc_pkg::HUE_MAX : i_hue_deg;
        w_sat = (i_saturation_pct > hrc_pkg::PCT_MAX) ? hrc_pkg::PCT_MAX
                                                      : i_saturation_pct;
        w_int = (i_intensity_pct > hrc_pkg::PCT_MAX) ? hrc_pkg::PCT_MAX
                                                     : i_intensity_pct;
        if (w_hue < hrc_pkg::HUE_SECTOR) begin
            w_sector = hrc_pkg::SEC_RG;
            w_deg    = hrc_pkg::DEG_W'(w_hue);
        end else if (w_hue < hrc_pkg::HUE_SECTOR2) begin
            w_sector = hrc_pkg::SEC_GB;
            w_deg    = hrc_pkg::DEG_W'(w_hue - hrc_pkg::HUE_SECTOR);
        end else begin
            w_sector = hrc_pkg::SEC_BR;
            w_deg    = hrc_pkg::DEG_W'(w_hue - hrc_pkg::HUE_SECTOR2);
        end
    end

    // Stage 0: clamped inputs and the ratio lookup.
    always_ff @(posedge i_clk) begin
        if (i_ctl.s0_en) begin
            r_s0_sector <= w_sector;
            r_s0_sat    <= w_sat;
            r_s0_int    <= w_int;
            r_s0_apri   <= hrc_pkg::ratio_pri(w_deg);
        end
    end

    // Stage 1: saturation times intensity, and the unsaturated share.
    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_s1_sector <= r_s0_sector;
            r_s1_si     <= hrc_pkg::PROD_W'(r_s0_sat) * hrc_pkg::PROD_W'(r_s0_int);
            r_s1_w      <= hrc_pkg::PROD_W'(hrc_pkg::PCT_MAX - r_s0_sat)
                           * hrc_pkg::PROD_W'(r_s0_int);
            r_s1_apri   <= r_s0_apri;
            r_s1_asec   <= hrc_pkg::RATIO_SUM - r_s0_apri;
        end
    end

    // Numerators over the common denominator; white is scaled by 49152 so
    // that all four channels share one divisor.
    assign w_xp = hrc_pkg::MUL_W'(r_s1_si) * hrc_pkg::MUL_W'(r_s1_apri);
    assign w_xs = hrc_pkg::MUL_W'(r_s1_si) * hrc_pkg::MUL_W'(r_s1_asec);
    assign w_xw = hrc_pkg::MUL_W'(r_s1_w) * hrc_pkg::MUL_W'(hrc_pkg::RATIO_SUM);

    // Route the primary and secondary numerators to their colors.
    always_comb begin
        n_x_red   = '0;
        n_x_green = '0;
        n_x_blue  = '0;
        case (r_s1_sector)
            hrc_pkg::SEC_RG: begin
                n_x_red   = w_xp[hrc_pkg::X_W-1:0];
                n_x_green = w_xs[hrc_pkg::X_W-1:0];
            end
            hrc_pkg::SEC_GB: begin
                n_x_green = w_xp[hrc_pkg::X_W-1:0];
                n_x_blue  = w_xs[hrc_pkg::X_W-1:0];
            end
            default: begin
                n_x_blue  = w_xp[hrc_pkg::X_W-1:0];
                n_x_red   = w_xs[hrc_pkg::X_W-1:0];
            end
        endcase
    end

    // Stage 2: per-channel numerators.
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_x_red   <= n_x_red;
            r_x_green <= n_x_green;
            r_x_blue  <= n_x_blue;
            r_x_white <= w_xw[hrc_pkg::X_W-1:0];
        end
    end

    assign o_x_red   = r_x_red;
    assign o_x_green = r_x_green;
    assign o_x_blue  = r_x_blue;
    assign o_x_white = r_x_white;

endmodule

// ----- sv/hrc_cdiv.sv -----
module hrc_cdiv #(
    parameter int DUTY_BITS = hrc_pkg::DUTY_BITS_DEF
) (
    input  logic                    i_clk,
    input  hrc_pkg::t_div_ctl       i_ctl,
    input  logic [hrc_pkg::X_W-1:0] i_x,
    output logic [DUTY_BITS-1:0]    o_duty
);

    // Result is floor(x * (2^DUTY_BITS - 1) / (1875 * 2^18)).
    localparam int Y_W   = hrc_pkg::X_W + DUTY_BITS;
    localparam int Z_W   = Y_W - hrc_pkg::DEN_SHIFT;
    localparam int M_W   = Z_W - $clog2(hrc_pkg::DEN_ODD) + 1;
    localparam int P_W   = Z_W + M_W;
    localparam int REM_W = $clog2(2 * hrc_pkg::DEN_ODD);
    localparam longint unsigned RECIP = (64'd1 << Z_W) / hrc_pkg::DEN_ODD;
    localparam logic [M_W-1:0]   RECIP_M = M_W'(RECIP);
    localparam logic [Z_W-1:0]   DIV_Z   = Z_W'(hrc_pkg::DEN_ODD);
    localparam logic [REM_W-1:0] DIV_R   = REM_W'(hrc_pkg::DEN_ODD);

    logic [Y_W-1:0]       w_y;
    logic [Z_W-1:0]       r_z;
    logic [Z_W-1:0]       r_z1;
    logic [P_W-1:0]       r_prod;
    logic [DUTY_BITS-1:0] w_qe;
    logic [Z_W-1:0]       w_back;
    logic [Z_W-1:0]       w_rem;
    logic [DUTY_BITS-1:0] r_qe;
    logic [REM_W-1:0]     r_rem;
    logic [DUTY_BITS-1:0] r_duty;

    // Stage 0: multiply by full scale as a shift and subtract, drop 2^18.
    assign w_y = (Y_W'(i_x) << DUTY_BITS) - Y_W'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_ctl.d0_en) begin
            r_z <= w_y[Y_W-1:hrc_pkg::DEN_SHIFT];
        end
    end

    // Stage 1: reciprocal multiply; the estimate is exact or one short.
    always_ff @(posedge i_clk) begin
        if (i_ctl.d1_en) begin
            r_prod <= P_W'(r_z) * P_W'(RECIP_M);
            r_z1   <= r_z;
        end
    end

    // Stage 2: estimate and its remainder.
    assign w_qe   = r_prod[Z_W +: DUTY_BITS];
    assign w_back = Z_W'(w_qe) * DIV_Z;
    assign w_rem  = r_z1 - w_back;

    always_ff @(posedge i_clk) begin
        if (i_ctl.d2_en) begin
            r_qe  <= w_qe;
            r_rem <= w_rem[REM_W-1:0];
        end
    end

    // Stage 3: one correction step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.d3_en) begin
            r_duty <= (r_rem >= DIV_R) ? r_qe + DUTY_BITS'(1) : r_qe;
        end
    end

    assign o_duty = r_duty;

endmodule

// ----- verif/hsi_to_rgbw_converter_checker.sv -----
module hsi_to_rgbw_converter_checker #(
    parameter int DUTY_BITS = hrc_pkg::DUTY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic                      i_req_ready,
    input  logic [hrc_pkg::HUE_W-1:0] i_hue_deg,
    input  logic [hrc_pkg::PCT_W-1:0] i_saturation_pct,
    input  logic [hrc_pkg::PCT_W-1:0] i_intensity_pct,
    input  logic                      i_duty_valid,
    input  logic                      i_duty_ready,
    input  logic [DUTY_BITS-1:0]      i_red_duty,
    input  logic [DUTY_BITS-1:0]      i_green_duty,
    input  logic [DUTY_BITS-1:0]      i_blue_duty,
    input  logic [DUTY_BITS-1:0]      i_white_duty,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DUTY_BITS-1:0] red;
        logic [DUTY_BITS-1:0] green;
        logic [DUTY_BITS-1:0] blue;
        logic [DUTY_BITS-1:0] white;
    } t_duty_set;

    localparam longint unsigned FULL_SCALE = (64'd1 << DUTY_BITS) - 64'd1;
    localparam longint unsigned CHROMA_DEN = 64'd30000 * 64'd16384;
    localparam int              Q14_ONE    = 16384;
    localparam int              Q14_HALF   = 8192;

    // Scaled tangent of the angle away from the sector midpoint, 0..60 degrees.
    localparam int TANGENT_Q14 [0:60] = '{
        0, 248, 495, 744, 992, 1241, 1491, 1742, 1994, 2247,
        2502, 2758, 3016, 3276, 3538, 3802, 4069, 4338, 4610, 4886,
        5164, 5447, 5733, 6023, 6317, 6616, 6920, 7230, 7544, 7865,
        8192, 8526, 8866, 9214, 9571, 9935, 10309, 10692, 11086, 11490,
        11906, 12334, 12776, 13231, 13702, 14189, 14693, 15216, 15758, 16323,
        16910, 17522, 18161, 18829, 19529, 20264, 21036, 21849, 22707, 23614,
        24576
    };

    t_duty_set duty_queue [$];
    int        mismatch_count = 0;
    int        checked_count  = 0;

    // Works out the four duty values that one color request should produce.
    function automatic t_duty_set predict_duty(input logic [hrc_pkg::HUE_W-1:0] hue,
                                               input logic [hrc_pkg::PCT_W-1:0] sat,
                                               input logic [hrc_pkg::PCT_W-1:0] inten);
        logic [hrc_pkg::HUE_W-1:0] h;
        logic [hrc_pkg::PCT_W-1:0] s;
        logic [hrc_pkg::PCT_W-1:0] i;
        hrc_pkg::t_sector          sector;
        int                        offset;
        int                        ratio;
        longint unsigned           chroma;
        longint unsigned           primary;
        longint unsigned           secondary;
        longint unsigned           white;
        t_duty_set                 res;
        h = (hue > hrc_pkg::HUE_MAX) ? hrc_pkg::HUE_MAX : hue;
        s = (sat > hrc_pkg::PCT_MAX) ? hrc_pkg::PCT_MAX : sat;
        i = (inten > hrc_pkg::PCT_MAX) ? hrc_pkg::PCT_MAX : inten;
        if (h < hrc_pkg::HUE_SECTOR) begin
            sector = hrc_pkg::SEC_RG;
            offset = int'(h);
        end else if (h < hrc_pkg::HUE_SECTOR2) begin
            sector = hrc_pkg::SEC_GB;
            offset = int'(h) - int'(hrc_pkg::HUE_SECTOR);
        end else begin
            sector = hrc_pkg::SEC_BR;
            offset = int'(h) - int'(hrc_pkg::HUE_SECTOR2);
        end
        // The ratio q is mirrored around the sector midpoint.
        if (offset <= int'(hrc_pkg::DEG_MID))
            ratio = Q14_HALF + TANGENT_Q14[int'(hrc_pkg::DEG_MID) - offset];
        else
            ratio = Q14_HALF - TANGENT_Q14[offset - int'(hrc_pkg::DEG_MID)];
        chroma    = longint'(s) * longint'(i) * FULL_SCALE;
        primary   = chroma * longint'(Q14_ONE + ratio) / CHROMA_DEN;
        secondary = chroma * longint'(2 * Q14_ONE - ratio) / CHROMA_DEN;
        white     = FULL_SCALE * longint'(hrc_pkg::PCT_MAX - s) * longint'(i) / 64'd10000;
        res.white = white[DUTY_BITS-1:0];
        case (sector)
            hrc_pkg::SEC_RG: begin
                res.red   = primary[DUTY_BITS-1:0];
                res.green = secondary[DUTY_BITS-1:0];
                res.blue  = '0;
            end
            hrc_pkg::SEC_GB: begin
                res.red   = '0;
                res.green = primary[DUTY_BITS-1:0];
                res.blue  = secondary[DUTY_BITS-1:0];
            end
            default: begin
                res.red   = secondary[DUTY_BITS-1:0];
                res.green = '0;
                res.blue  = primary[DUTY_BITS-1:0];
            end
        endcase
        return res;
    endfunction

    // Predict on each accepted request and compare each accepted result.
    always @(posedge i_clk) begin
        t_duty_set got;
        t_duty_set want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                duty_queue.push_back(predict_duty(i_hue_deg, i_saturation_pct,
                                                  i_intensity_pct));
            if (i_duty_valid && i_duty_ready) begin
                got = '{i_red_duty, i_green_duty, i_blue_duty, i_white_duty};
                checked_count++;
                if (duty_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request pending: %s%0d %0d %0d %0d",
                                 $realtime, "r g b w = ",
                                 got.red, got.green, got.blue, got.white);
                end else begin
                    want = duty_queue.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.white !== want.white) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: duty mismatch: expected r=%0d g=%0d b=%0d w=%0d,%s",
                                     $realtime, want.red, want.green, want.blue,
                                     want.white, " got:");
                        if (mismatch_count <= 10)
                            $display("    got r=%0d g=%0d b=%0d w=%0d",
                                     got.red, got.green, got.blue, got.white);
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_checked    <= checked_count;
        o_pending    <= duty_queue.size();
    end

endmodule

// ----- verif/hsi_to_rgbw_converter_top_test.sv -----
module hsi_to_rgbw_converter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_BITS       = 12;
    localparam int RANDOM_PER_MODE = 457;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;

    // Idle and stall percentages of the four random traffic phases.
    localparam int MODE_IDLE  [4] = '{0, 63, 0, 30};
    localparam int MODE_STALL [4] = '{0, 0, 63, 30};

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_valid          = 1'b0;
    logic                          o_ready;
    logic [hrc_pkg::HUE_W-1:0]     i_hue_deg        = '0;
    logic [hrc_pkg::PCT_W-1:0]     i_saturation_pct = '0;
    logic [hrc_pkg::PCT_W-1:0]     i_intensity_pct  = '0;
    logic                          o_valid;
    logic                          i_ready          = 1'b0;
    logic [DUTY_BITS-1:0]          o_red_duty;
    logic [DUTY_BITS-1:0]          o_green_duty;
    logic [DUTY_BITS-1:0]          o_blue_duty;
    logic [DUTY_BITS-1:0]          o_white_duty;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count   = 0;
    int sent_count    = 0;
    int clamped_count = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;

    hsi_to_rgbw_converter_top #(.DUTY_BITS(DUTY_BITS)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_hue_deg        (i_hue_deg),
        .i_saturation_pct (i_saturation_pct),
        .i_intensity_pct  (i_intensity_pct),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_red_duty       (o_red_duty),
        .o_green_duty     (o_green_duty),
        .o_blue_duty      (o_blue_duty),
        .o_white_duty     (o_white_duty)
    );

    hsi_to_rgbw_converter_checker #(.DUTY_BITS(DUTY_BITS)) duty_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_hue_deg        (i_hue_deg),
        .i_saturation_pct (i_saturation_pct),
        .i_intensity_pct  (i_intensity_pct),
        .i_duty_valid     (o_valid),
        .i_duty_ready     (i_ready),
        .i_red_duty       (o_red_duty),
        .i_green_duty     (o_green_duty),
        .i_blue_duty      (o_blue_duty),
        .i_white_duty     (o_white_duty),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count),
        .o_checked        (checked_count)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver stalls at random with the current stall percentage.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out with %0d results still pending.", pending_count);
        $display("[hsi_to_rgbw_converter_top] ERROR");
        $finish;
    end

    // Offers one color request, idling first at random, and waits for acceptance.
    task automatic send_color(input logic [hrc_pkg::HUE_W-1:0] hue,
                              input logic [hrc_pkg::PCT_W-1:0] sat,
                              input logic [hrc_pkg::PCT_W-1:0] inten);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_hue_deg        <= hue;
        i_saturation_pct <= sat;
        i_intensity_pct  <= inten;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sent_count++;
        if (hue > hrc_pkg::HUE_MAX || sat > hrc_pkg::PCT_MAX || inten > hrc_pkg::PCT_MAX)
            clamped_count++;
    endtask

    // Mostly legal hues, with a share above the clamp point.
    function automatic logic [hrc_pkg::HUE_W-1:0] pick_hue();
        if ($urandom_range(99) < 80)
            return hrc_pkg::HUE_W'($urandom_range(int'(hrc_pkg::HUE_MAX), 0));
        return hrc_pkg::HUE_W'($urandom_range(511, int'(hrc_pkg::HUE_MAX) + 1));
    endfunction

    // Mostly legal percentages, with a share above the clamp point.
    function automatic logic [hrc_pkg::PCT_W-1:0] pick_pct();
        if ($urandom_range(99) < 85)
            return hrc_pkg::PCT_W'($urandom_range(int'(hrc_pkg::PCT_MAX), 0));
        return hrc_pkg::PCT_W'($urandom_range(127, int'(hrc_pkg::PCT_MAX) + 1));
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: field extremes, sector edges and the clamps.
        send_color(9'd0,   7'd0,   7'd0);
        send_color(9'd0,   7'd100, 7'd100);
        send_color(9'd511, 7'd127, 7'd127);
        send_color(9'd360, 7'd100, 7'd100);
        send_color(9'd361, 7'd100, 7'd100);
        send_color(9'd59,  7'd100, 7'd100);
        send_color(9'd60,  7'd100, 7'd100);
        send_color(9'd61,  7'd100, 7'd100);
        send_color(9'd119, 7'd100, 7'd100);
        send_color(9'd120, 7'd100, 7'd100);
        send_color(9'd121, 7'd50,  7'd100);
        send_color(9'd239, 7'd100, 7'd100);
        send_color(9'd240, 7'd100, 7'd100);
        send_color(9'd241, 7'd100, 7'd75);
        send_color(9'd359, 7'd100, 7'd100);
        send_color(9'd180, 7'd0,   7'd100);
        send_color(9'd180, 7'd0,   7'd127);
        send_color(9'd300, 7'd101, 7'd100);
        send_color(9'd30,  7'd100, 7'd101);
        send_color(9'd256, 7'd64,  7'd64);
        send_color(9'd90,  7'd1,   7'd1);
        send_color(9'd200, 7'd99,  7'd99);

        // Random requests under four flow-control patterns.
        for (int mode = 0; mode < 4; mode++) begin
            idle_pct  = MODE_IDLE[mode];
            stall_pct = MODE_STALL[mode];
            for (int n = 0; n < RANDOM_PER_MODE; n++) begin
                if ($urandom_range(99) < 5)
                    send_color(hrc_pkg::HUE_W'($urandom()), hrc_pkg::PCT_W'($urandom()),
                               hrc_pkg::PCT_W'($urandom()));
                else
                    send_color(pick_hue(), pick_pct(), pick_pct());
            end
        end
        i_valid   <= 1'b0;
        stall_pct  = 0;

        // Drain the pipeline, then keep the clock running before the report.
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d color requests (%0d with clamped fields) under four traffic patterns.",
                 sent_count, clamped_count);
        $display("Compared %0d duty results, %0d failures.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("[hsi_to_rgbw_converter_top] OK");
        else
            $display("[hsi_to_rgbw_converter_top] ERROR");
        $finish;
    end

endmodule
